// File: design/splim_pkg.sv
// Shared types, widths and helpers for the speed profile acceleration limiter.
`timescale 1ns / 1ps
`default_nettype none

package splim_pkg;

  // Radicand magnitude stays below 2^50, so its root fits in 25 bits.
  localparam int RAD_W  = 50;
  localparam int ROOT_W = RAD_W / 2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ACCEL = 2'd0;
  localparam logic [1:0] REG_DECEL = 2'd1;

  // Configuration reset values, Q8.8 m/s^2.
  localparam logic [15:0] ACCEL_RESET = 16'd256;
  localparam logic [15:0] DECEL_RESET = 16'd512;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MULV = 6'b000010,
    ST_MULD = 6'b000100,
    ST_RAD  = 6'b001000,
    ST_SQRT = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  // Control from the sequencer to the square root unit.
  typedef struct packed {
    logic start;
  } sqrt_ctrl_t;

  // Status from the square root unit back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

  // Clamp a signed 26-bit speed to the range 0 .. 32767.
  function automatic logic signed [15:0] clamp_speed(input logic signed [25:0] val);
    logic signed [15:0] res;
    if (val[25]) begin
      res = 16'sd0;
    end else if (val > 26'sd32767) begin
      res = 16'sd32767;
    end else begin
      res = val[15:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: design/splim_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module splim_sqrt import splim_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sqrt_ctrl_t        ctrl,
  input  wire logic [RAD_W-1:0]  radicand,
  output sqrt_stat_t             stat,
  output logic [ROOT_W-1:0]      root
);

  localparam logic [RAD_W-1:0] START_PROBE = RAD_W'(1) << (RAD_W - 2);
  localparam logic [RAD_W-1:0] LAST_PROBE  = RAD_W'(1);

  logic [RAD_W-1:0] rem;
  logic [RAD_W-1:0] res;
  logic [RAD_W-1:0] probe;
  logic [RAD_W-1:0] trial;
  logic             busy;
  logic             done;

  // Trial subtrahend for the current digit.
  assign trial = res + probe;

  // Control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && probe == LAST_PROBE) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: one restoring step per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem   <= radicand;
      res   <= '0;
      probe <= START_PROBE;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + probe;
      end else begin
        res <= res >> 1;
      end
      probe <= probe >> 2;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign root      = res[ROOT_W-1:0];

endmodule

`default_nettype wire

// File: design/speed_profile_accel_limiter_unit.sv
// Top level of the speed profile acceleration limiter.
// Path: a first point or a point at the previous speed goes from idle straight to the final state;
// others pass the multiply states and the radicand state, then go to the final state on a negative
// radicand, else run the 25-step square root first. Throughput: one item at a time; the next item
// is accepted once the sequencer leaves its final state, which a stalled output register delays.
// Reset (synchronous): limits return to 256 and 512, previous position and speed to zero.
`timescale 1ns / 1ps
`default_nettype none

module speed_profile_accel_limiter_unit import splim_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] downtrack,
  input  wire logic signed [15:0] target_speed,
  input  wire logic               first_point,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      limited_speed
);

  state_t state;

  logic [15:0]        max_accel;
  logic [15:0]        max_decel;
  logic signed [31:0] prev_position;
  logic signed [15:0] last_speed;

  logic signed [31:0] pos;
  logic signed [15:0] tgt;
  logic signed [32:0] delta_pos;
  logic               going_up;
  logic [30:0]        vsq;
  logic signed [48:0] term;
  logic signed [15:0] result;

  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  logic signed [50:0] rad;
  logic [15:0]        limit_sel;

  sqrt_ctrl_t         sq_ctrl;
  sqrt_stat_t         sq_stat;
  logic [ROOT_W-1:0]  root;
  logic signed [25:0] root_s;
  logic signed [25:0] tgt_s;
  logic signed [25:0] pick;

  logic in_fire;
  logic out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state == ST_FIN) && (!out_valid || out_ready);

  // Shared multiplier: previous speed squared, then limit times distance.
  assign limit_sel = going_up ? max_accel : max_decel;
  assign mul_a = (state == ST_MULD) ? delta_pos : {{17{last_speed[15]}}, last_speed};
  assign mul_b = (state == ST_MULD) ? {1'b0, limit_sel} : {last_speed[15], last_speed};
  assign mul_p = mul_a * mul_b;

  // Radicand: v_prev^2 plus or minus twice the limit-distance product.
  always_comb begin
    if (going_up) begin
      rad = {20'd0, vsq} + {term[48], term, 1'b0};
    end else begin
      rad = {20'd0, vsq} - {term[48], term, 1'b0};
    end
  end

  assign sq_ctrl.start = (state == ST_RAD) && !rad[50];

  splim_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (sq_ctrl),
    .radicand (rad[RAD_W-1:0]),
    .stat     (sq_stat),
    .root     (root)
  );

  // Bound selection: cap a rise, floor a fall.
  assign root_s = {1'b0, root};
  assign tgt_s  = {{10{tgt[15]}}, tgt};
  always_comb begin
    if (going_up) begin
      pick = (tgt_s < root_s) ? tgt_s : root_s;
    end else begin
      pick = (tgt_s > root_s) ? tgt_s : root_s;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_accel <= ACCEL_RESET;
      max_decel <= DECEL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ACCEL: max_accel <= cfg_data;
        REG_DECEL: max_decel <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, trajectory state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      prev_position <= '0;
      last_speed    <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (first_point) begin
              state <= ST_FIN;
            end else if (target_speed == last_speed) begin
              state <= ST_FIN;
            end else begin
              state <= ST_MULV;
            end
          end
        end
        ST_MULV: state <= ST_MULD;
        ST_MULD: state <= ST_RAD;
        ST_RAD: begin
          state <= rad[50] ? ST_FIN : ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_stat.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            prev_position <= pos;
            last_speed    <= result;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          pos       <= downtrack;
          tgt       <= target_speed;
          delta_pos <= {downtrack[31], downtrack} - {prev_position[31], prev_position};
          going_up  <= target_speed > last_speed;
          if (first_point) begin
            result <= target_speed;
          end else begin
            result <= clamp_speed({{10{target_speed[15]}}, target_speed});
          end
        end
      end
      ST_MULV: vsq  <= mul_p[30:0];
      ST_MULD: term <= mul_p[48:0];
      ST_SQRT: begin
        if (sq_stat.done) begin
          result <= clamp_speed(pick);
        end
      end
      ST_FIN: begin
        if (out_load) begin
          limited_speed <= result;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: design/splim_checker.sv
// Port-level checker for the speed profile acceleration limiter, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module splim_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready,
  input wire logic [1:0]         cfg_index,
  input wire logic [15:0]        cfg_data,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic signed [31:0] downtrack,
  input wire logic signed [15:0] target_speed,
  input wire logic               first_point,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] limited_speed
);

  logic [1:0] pend;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Count items accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
    end else if (in_fire && !out_fire) begin
      pend <= pend + 2'd1;
    end else if (out_fire && !in_fire) begin
      pend <= pend - 2'd1;
    end
  end

  // A result is only ever shown for an item that was taken in.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 2'd0)
    else $error("result shown with no item outstanding");

  // An accepted item carries a known payload, and the block then works on it alone.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> !$isunknown({downtrack, target_speed, first_point}) ##1 !in_ready)
    else $error("unknown item taken or input still ready right after an item");

  // Register writes carry known values and land while no item is in flight.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> pend == 2'd0 && !$isunknown({cfg_index, cfg_data}))
    else $error("register write while an item is in flight");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(limited_speed))
    else $error("stalled result changed or dropped");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind speed_profile_accel_limiter_unit splim_checker u_splim_checker (.*);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the speed profile acceleration limiter.
`timescale 1ns / 1ps

module tb;
  import splim_pkg::*;

  // Register index that the block does not implement; writes to it are ignored.
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int STALL_CYCLES = 400;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [15:0] target;
    logic               first;
  } speed_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [31:0]  downtrack = '0;
  logic signed [15:0]  target_speed = '0;
  logic                first_point = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [15:0]  limited_speed;

  // Points waiting to be driven and limited speeds waiting to come out.
  speed_point_t        point_queue[$];
  logic signed [15:0]  speed_expect[$];
  speed_point_t        cur_point;
  logic signed [15:0]  want_speed;

  // Predictor copy of the block's registers and trajectory state.
  logic [15:0]         model_accel = ACCEL_RESET;
  logic [15:0]         model_decel = DECEL_RESET;
  logic signed [31:0]  model_pos = '0;
  logic signed [15:0]  model_speed = '0;

  int send_idle_pct = 38;
  int recv_idle_pct = 78;
  logic hold_off = 1'b0;
  logic stall_req = 1'b0;
  int stall_count = 0;
  int mismatch_count = 0;

  speed_profile_accel_limiter_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .downtrack    (downtrack),
    .target_speed (target_speed),
    .first_point  (first_point),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .limited_speed(limited_speed)
  );

  always #10 clk = ~clk;

  // Floor of the square root, found one result bit at a time.
  function automatic logic [31:0] floor_sqrt(input logic [63:0] radicand);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= radicand) begin
        root = trial;
      end
    end
    return root[31:0];
  endfunction

  // Limits one point against the previous output and advances the trajectory state.
  function automatic logic signed [15:0] step_limiter(input speed_point_t p);
    longint dist_q8;
    longint vprev;
    longint rad;
    longint bound;
    longint res;
    res = longint'(p.target);
    if (!p.first) begin
      dist_q8 = longint'(p.pos) - longint'(model_pos);
      vprev   = longint'(model_speed);
      if (res > vprev) begin
        rad = vprev * vprev + 2 * longint'(model_accel) * dist_q8;
        if (rad >= 0) begin
          bound = longint'(floor_sqrt(rad));
          res = (res < bound) ? res : bound;
        end
      end else if (res < vprev) begin
        rad = vprev * vprev - 2 * longint'(model_decel) * dist_q8;
        if (rad >= 0) begin
          bound = longint'(floor_sqrt(rad));
          res = (res > bound) ? res : bound;
        end
      end
      if (res < 0) begin
        res = 0;
      end
      if (res > 32767) begin
        res = 32767;
      end
    end
    model_pos   = p.pos;
    model_speed = res[15:0];
    return res[15:0];
  endfunction

  // Input driver: predicts each accepted item, then offers the next one at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        speed_expect = {speed_expect, step_limiter(cur_point)};
      end
      if (!in_valid || in_ready) begin
        if (point_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_point = point_queue.pop_front();
          in_valid     <= 1'b1;
          downtrack    <= cur_point.pos;
          target_speed <= cur_point.target;
          first_point  <= cur_point.first;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each accepted item with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (speed_expect.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected limited_speed %0d with nothing pending", limited_speed);
        end
      end else begin
        want_speed = speed_expect.pop_front();
        if (limited_speed !== want_speed) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("limited_speed mismatch: expected %0d, got %0d",
                     want_speed, limited_speed);
          end
        end
      end
    end
    out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Long receiver stall: once requested, the receiver holds off until its counter reaches STALL_CYCLES, only once.
  always @(posedge clk) begin
    if (hold_off) begin
      stall_count <= stall_count + 1;
      if (stall_count == STALL_CYCLES - 1) begin
        hold_off <= 1'b0;
      end
    end else if (stall_req && stall_count == 0) begin
      hold_off <= 1'b1;
    end
  end

  task automatic push_point(input logic signed [31:0] pos, input logic signed [15:0] target,
                            input logic first);
    speed_point_t p;
    p.pos    = pos;
    p.target = target;
    p.first  = first;
    point_queue = {point_queue, p};
  endtask

  // Keeps random targets near a plausible speed so that the limits engage.
  function automatic logic signed [15:0] model_speed_hint(input int spd);
    logic signed [15:0] s;
    s = spd[15:0];
    return (s < 0) ? 16'sd200 : s;
  endfunction

  // Mostly well-formed trajectories with nearby positions and speeds, plus some noise.
  task automatic queue_random_points(input int count);
    logic signed [31:0] pos;
    int spd;
    int kind;
    pos = $urandom;
    spd = $urandom_range(0, 8000);
    push_point(pos, spd[15:0], 1'b1);
    for (int n = 1; n < count; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        pos = $urandom;
        spd = $urandom_range(0, 65535);
        push_point(pos, spd[15:0], 1'b1);
      end else if (kind < 12) begin
        push_point(32'($urandom), 16'($urandom), 1'b0);
      end else begin
        if (kind < 80) begin
          pos = pos + $urandom_range(0, 2048);
        end else if (kind < 93) begin
          pos = pos - $urandom_range(0, 512);
        end else begin
          pos = pos + $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
        end
        if (kind % 7 == 0) begin
          spd = $urandom_range(0, 65535);
        end else begin
          spd = int'(model_speed_hint(spd)) + $urandom_range(0, 1600) - 800;
        end
        push_point(pos, spd[15:0], 1'b0);
      end
    end
  endtask

  // Register write; valid stays high for back-to-back writes and is lowered by the caller.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      REG_ACCEL: begin
        model_accel = val;
      end
      REG_DECEL: begin
        model_decel = val;
      end
      default: begin
      end
    endcase
  endtask

  // Waits until every item is out, checked away from the rising edge, then rejoins the edge.
  task automatic wait_drained();
    @(negedge clk);
    while (point_queue.size() != 0 || in_valid || speed_expect.size() != 0) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // Stimulus sequence: directed points, then random phases under several limit settings.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // No first point after reset: zero state acts as the previous point.
    push_point(32'sd1000, 16'sd3000, 1'b0);
    // First points pass unchanged, negative speed included.
    push_point(32'sd0, -16'sd32768, 1'b1);
    push_point(32'sh7FFF_FFFF, 16'sd32767, 1'b1);
    // Long backward move under deceleration: the root exceeds the speed range and the result saturates.
    push_point(-32'sh8000_0000, -16'sd5, 1'b0);
    // Target equal to the previous output.
    push_point(-32'sh8000_0000, 16'sd32767, 1'b0);
    push_point(32'sd0, 16'sd100, 1'b1);
    push_point(32'sd0, 16'sd100, 1'b0);
    // Backward move under acceleration: negative radicand keeps the target.
    push_point(-32'sd100, 16'sd200, 1'b0);
    push_point(-32'sd200, 16'sd0, 1'b0);
    // Negative target with negative radicand clamps to zero.
    push_point(32'sd1000, -16'sd32768, 1'b0);
    push_point(32'sd5000, 16'sd5000, 1'b1);
    push_point(32'sd5256, 16'sd32767, 1'b0);
    push_point(32'sd6000, 16'sd0, 1'b0);
    push_point(32'sd6000, 16'sd32767, 1'b0);
    push_point(32'sd6000, -16'sd1, 1'b0);
    push_point(32'sd9000, 16'sd1, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        1: begin
          write_reg(REG_ACCEL, 16'd1);
          write_reg(REG_DECEL, 16'd65535);
          write_reg(REG_SPARE, 16'($urandom));
          cfg_valid <= 1'b0;
        end
        2: begin
          write_reg(REG_ACCEL, 16'd65535);
          write_reg(REG_DECEL, 16'd1);
          cfg_valid <= 1'b0;
        end
        3: begin
          write_reg(REG_ACCEL, 16'd0);
          write_reg(REG_DECEL, 16'd0);
          cfg_valid <= 1'b0;
        end
        4: begin
          write_reg(REG_ACCEL, 16'($urandom_range(1, 65535)));
          write_reg(REG_DECEL, 16'($urandom_range(1, 65535)));
          cfg_valid <= 1'b0;
        end
        5: begin
          write_reg(REG_ACCEL, ACCEL_RESET);
          write_reg(REG_DECEL, DECEL_RESET);
          cfg_valid <= 1'b0;
        end
        default: begin
        end
      endcase
      if (ph < 2) begin
        send_idle_pct <= 38;
        recv_idle_pct <= 78;
      end else if (ph < 4) begin
        send_idle_pct <= 78;
        recv_idle_pct <= 38;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      queue_random_points(315);
      // Long output stall while the sender keeps offering items.
      if (ph == 4) begin
        stall_req <= 1'b1;
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && speed_expect.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
